/* rtl/chf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chf_pkg: shared types and constants for the compass heading core
// fixed-point formats, arctangent table and pipeline item type
// ----------------------------------------------------------------------------
package chf_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int STEPS_RUN    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   // samples scaled by 2^32; the floor shifts drop low bits from the ninth step on
   localparam int FRAC_W = 32;
   localparam int WORK_W = SAMPLE_BITS + 3 + FRAC_W;
   localparam int ANG_W  = 28;
   localparam int IDX_W  = 5;
   localparam int Q6_W   = 15;

   localparam int ROUND_SHIFT = 10;
   localparam int ROUND_BIAS  = 512;
   localparam int ANG_HALF    = 180 * 65536;
   localparam int ANG_FULL    = 360 * 65536;
   localparam int FULL_TURN_Q6 = 23040;

   typedef logic signed [WORK_W-1:0] work_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [Q6_W-1:0]          q6_type;
   typedef logic [1:0]               spc_type;

   // headings of samples that lie on an axis
   localparam spc_type SPC_ZERO  = 2'd0;
   localparam spc_type SPC_HALF  = 2'd1;
   localparam spc_type SPC_QUART = 2'd2;
   localparam spc_type SPC_THREE = 2'd3;

   typedef struct packed {
      work_type x;
      work_type y;
      ang_type  z;
      logic     on_axis;
      spc_type  axis_code;
   } item_type;

   function automatic q6_type axis_heading(input spc_type code);
      q6_type h;
      case (code)
         SPC_ZERO:  h = q6_type'(0);
         SPC_HALF:  h = q6_type'(180 * 64);
         SPC_QUART: h = q6_type'(90 * 64);
         SPC_THREE: h = q6_type'(270 * 64);
         default:   h = q6_type'(0);
      endcase
      return h;
   endfunction

   // round(atan(2^-i) * 180/pi * 65536)
   function automatic ang_type atan_q16(input idx_type i);
      ang_type a;
      case (i)
         5'd0:    a = ang_type'(2949120);
         5'd1:    a = ang_type'(1740967);
         5'd2:    a = ang_type'(919879);
         5'd3:    a = ang_type'(466945);
         5'd4:    a = ang_type'(234379);
         5'd5:    a = ang_type'(117304);
         5'd6:    a = ang_type'(58666);
         5'd7:    a = ang_type'(29335);
         5'd8:    a = ang_type'(14668);
         5'd9:    a = ang_type'(7334);
         5'd10:   a = ang_type'(3667);
         5'd11:   a = ang_type'(1833);
         5'd12:   a = ang_type'(917);
         5'd13:   a = ang_type'(458);
         5'd14:   a = ang_type'(229);
         5'd15:   a = ang_type'(115);
         5'd16:   a = ang_type'(57);
         5'd17:   a = ang_type'(29);
         5'd18:   a = ang_type'(14);
         5'd19:   a = ang_type'(7);
         5'd20:   a = ang_type'(4);
         5'd21:   a = ang_type'(2);
         5'd22:   a = ang_type'(1);
         default: a = ang_type'(0);
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* rtl/chf_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chf_stage: one vectoring micro-rotation with its pipeline register
// turns the vector towards the x axis and accumulates the table angle
// ----------------------------------------------------------------------------
module chf_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire chf_pkg::idx_type  step_idx,
   input  wire logic              up_valid,
   input  wire chf_pkg::item_type up_item,
   input  wire logic              dn_en,
   output logic                   en,
   output logic                   valid,
   output chf_pkg::item_type      item
);

   logic              valid_ff;
   chf_pkg::item_type item_ff;
   chf_pkg::item_type item_in;
   chf_pkg::work_type xs;
   chf_pkg::work_type ys;
   logic              y_pos;

   assign en = !valid_ff || dn_en;

   always_comb begin
      xs    = up_item.x >>> step_idx;
      ys    = up_item.y >>> step_idx;
      y_pos = !up_item.y[chf_pkg::WORK_W-1] && (up_item.y != '0);
      item_in = up_item;
      if (y_pos) begin
         item_in.x = up_item.x + ys;
         item_in.y = up_item.y - xs;
         item_in.z = up_item.z + chf_pkg::atan_q16(step_idx);
      end else begin
         item_in.x = up_item.x - ys;
         item_in.y = up_item.y + xs;
         item_in.z = up_item.z - chf_pkg::atan_q16(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule
`default_nettype wire

/* rtl/compass_heading_from_field_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_from_field_core: flat compass heading from an x/y field
// atan2(y, x) in 1/64 degree over [0, 360) by a pipelined cordic vectoring
// ----------------------------------------------------------------------------
//  channel | dir | tdata bits (low first)          | tuser
//  req_    | in  | field_x[15:0], field_y[31:16]   | -
//  rsp_    | out | heading_q6[14:0], zero pad [15] | -
//
//  one input stage, one stage per micro-rotation (16) and a wrap and
//  rounding stage; one request per cycle while responses are taken.
//  reset clears only the valid bits; payload registers carry no reset.
//  each stage holds when its successor is full and stalled, so bubbles
//  close up and a stalled response still lets requests enter.
// ----------------------------------------------------------------------------
module compass_heading_from_field_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // field_x [15:0], field_y [31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // heading_q6 [14:0], zero [15]
);

   localparam int N = chf_pkg::STEPS_RUN;

   logic                                  v [0:N];
   chf_pkg::item_type                     it [0:N];
   logic                                  en [0:N+1];

   logic signed [chf_pkg::SAMPLE_BITS-1:0] sx;
   logic signed [chf_pkg::SAMPLE_BITS-1:0] sy;
   chf_pkg::work_type                      xm;
   chf_pkg::work_type                      ym;
   chf_pkg::item_type                      prep_in;
   logic                                   prep_v_ff;
   chf_pkg::item_type                      prep_ff;

   logic                  out_v_ff;
   chf_pkg::q6_type       out_ff;
   chf_pkg::q6_type       out_in;
   chf_pkg::ang_type      z_wrap;
   chf_pkg::ang_type      z_rnd;
   logic [chf_pkg::ANG_W-chf_pkg::ROUND_SHIFT-1:0] q_full;

   // input stage: axis cases, half-turn for negative x, scale to working format
   always_comb begin
      sx = req_tdata[chf_pkg::SAMPLE_BITS-1:0];
      sy = req_tdata[16 +: chf_pkg::SAMPLE_BITS];
      prep_in.on_axis   = (sx == '0) || (sy == '0);
      if (sy == '0) begin
         prep_in.axis_code = sx[chf_pkg::SAMPLE_BITS-1] ? chf_pkg::SPC_HALF
                                                        : chf_pkg::SPC_ZERO;
      end else begin
         prep_in.axis_code = sy[chf_pkg::SAMPLE_BITS-1] ? chf_pkg::SPC_THREE
                                                        : chf_pkg::SPC_QUART;
      end
      xm = chf_pkg::work_type'(sx) <<< chf_pkg::FRAC_W;
      ym = chf_pkg::work_type'(sy) <<< chf_pkg::FRAC_W;
      if (sx[chf_pkg::SAMPLE_BITS-1]) begin
         prep_in.x = -xm;
         prep_in.y = -ym;
         prep_in.z = chf_pkg::ang_type'(chf_pkg::ANG_HALF);
      end else begin
         prep_in.x = xm;
         prep_in.y = ym;
         prep_in.z = '0;
      end
   end

   assign en[0]      = !prep_v_ff || en[1];
   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_v_ff <= 1'b0;
      end else if (en[0]) begin
         prep_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prep_ff <= prep_in;
      end
   end

   assign v[0]  = prep_v_ff;
   assign it[0] = prep_ff;

   for (genvar g = 1; g <= N; g++) begin : g_step
      chf_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .step_idx (chf_pkg::idx_type'(g - 1)),
         .up_valid (v[g-1]),
         .up_item  (it[g-1]),
         .dn_en    (en[g+1]),
         .en       (en[g]),
         .valid    (v[g]),
         .item     (it[g])
      );
   end

   // wrap into a full turn and round half up to 1/64 degree; axis samples take their fixed heading
   always_comb begin
      z_wrap = it[N].z[chf_pkg::ANG_W-1]
               ? it[N].z + chf_pkg::ang_type'(chf_pkg::ANG_FULL) : it[N].z;
      z_rnd  = z_wrap + chf_pkg::ang_type'(chf_pkg::ROUND_BIAS);
      q_full = z_rnd[chf_pkg::ANG_W-1:chf_pkg::ROUND_SHIFT];
      if (it[N].on_axis) begin
         out_in = chf_pkg::axis_heading(it[N].axis_code);
      end else if (q_full >= (chf_pkg::ANG_W-chf_pkg::ROUND_SHIFT)'(chf_pkg::FULL_TURN_Q6)) begin
         out_in = '0;
      end else begin
         out_in = q_full[chf_pkg::Q6_W-1:0];
      end
   end

   assign en[N+1] = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en[N+1]) begin
         out_v_ff <= v[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en[N+1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, out_ff};

endmodule
`default_nettype wire

/* sim/compass_heading_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_checker: response checker for the compass heading core
// watches both stream channels, works out the heading of every accepted
// request and compares each response with the oldest heading still owed
// ----------------------------------------------------------------------------
module compass_heading_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // field_x [15:0], field_y [31:16]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // heading_q6 [14:0], zero [15]
   output int               mismatch_count,
   output int               pending_count
);

   // arctangent of 2^-i in q16 degrees
   longint arc_table [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   chf_pkg::q6_type heading_queue [$];

   function automatic chf_pkg::q6_type heading_of_field(input logic signed [15:0] fx,
                                                        input logic signed [15:0] fy);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint q6;
      if (fy == 0)
         return (fx < 0) ? chf_pkg::q6_type'(180 * 64) : chf_pkg::q6_type'(0);
      if (fx == 0)
         return (fy > 0) ? chf_pkg::q6_type'(90 * 64) : chf_pkg::q6_type'(270 * 64);
      x = longint'(fx);
      y = longint'(fy);
      z = 0;
      // left half plane: turn by half a revolution first
      if (x < 0) begin
         x = -x;
         y = -y;
         z = longint'(180) * 65536;
      end
      x = x * 64'sd4294967296;
      y = y * 64'sd4294967296;
      for (int i = 0; i < chf_pkg::STEPS_RUN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arc_table[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - arc_table[i];
         end
      end
      if (z < 0)
         z = z + longint'(360) * 65536;
      q6 = (z + 512) >>> 10;
      if (q6 >= 23040)
         q6 = 0;
      return chf_pkg::q6_type'(q6);
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            heading_queue.push_back(heading_of_field(req_tdata[15:0], req_tdata[31:16]));
         if (rsp_tvalid && rsp_tready) begin
            if (heading_queue.size() == 0) begin
               $error("heading_q6 response with no request outstanding: actual %0d",
                      rsp_tdata[14:0]);
               mismatch_count <= mismatch_count + 1;
            end else begin
               if (rsp_tdata[14:0] !== heading_queue[0]) begin
                  $error("heading_q6 mismatch: expected %0d, actual %0d",
                         heading_queue[0], rsp_tdata[14:0]);
                  mismatch_count <= mismatch_count + 1;
               end
               void'(heading_queue.pop_front());
            end
         end
         pending_count <= heading_queue.size();
      end
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the compass heading core
// axis, quadrant and wrap-around samples first, then random field samples
// with random gaps and response stalls and one long response hold-off
// ----------------------------------------------------------------------------
module testbench;

   localparam int  RANDOM_SAMPLES = 950;
   localparam int  HOLD_CYCLES    = 400;
   localparam int  DRAIN_CYCLES   = 40;
   localparam int  CYCLE_LIMIT    = 300000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // field_x [15:0], field_y [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // heading_q6 [14:0], zero [15]

   int mismatch_count;
   int pending_count;
   int cycle_count;
   bit req_gaps_on;
   bit rsp_stalls_on;
   bit hold_rsp;

   compass_heading_from_field_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   compass_heading_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      cycle_count   = 0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      hold_rsp      = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_field(input logic signed [15:0] fx, input logic signed [15:0] fy);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {fy, fx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic random_field(output logic signed [15:0] fx, output logic signed [15:0] fy);
      fx = 16'($urandom);
      fy = 16'($urandom);
      case ($urandom_range(0, 5))
         3: begin
            fx = 16'(int'($urandom_range(0, 16)) - 8);
            fy = 16'(int'($urandom_range(0, 16)) - 8);
         end
         4: begin
            if ($urandom_range(0, 1)) fx = '0;
            else fy = '0;
         end
         5: begin
            // just off an axis
            if ($urandom_range(0, 1)) fx = 16'(int'($urandom_range(0, 4)) - 2);
            else fy = 16'(int'($urandom_range(0, 4)) - 2);
         end
         default: ;
      endcase
   endtask

   // response side: random stalls, plus one long hold-off when asked
   initial begin
      int stall;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = rsp_stalls_on ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      int mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero field, both axes, corners and diagonals
      send_field(16'sd0, 16'sd0);
      send_field(16'sd1, 16'sd0);
      send_field(-16'sd1, 16'sd0);
      send_field(16'sd32767, 16'sd0);
      send_field(-16'sd32768, 16'sd0);
      send_field(16'sd0, 16'sd1);
      send_field(16'sd0, -16'sd1);
      send_field(16'sd0, 16'sd32767);
      send_field(16'sd0, -16'sd32768);
      send_field(16'sd32767, 16'sd32767);
      send_field(-16'sd32768, -16'sd32768);
      send_field(16'sd32767, -16'sd32768);
      send_field(-16'sd32768, 16'sd32767);
      send_field(16'sd1, 16'sd1);
      send_field(-16'sd1, 16'sd1);
      send_field(-16'sd1, -16'sd1);
      send_field(16'sd1, -16'sd1);
      // just below a full turn, rounds up to 360 and wraps to zero
      send_field(16'sd32767, -16'sd1);
      send_field(16'sd32767, 16'sd1);
      send_field(-16'sd32768, 16'sd1);
      send_field(-16'sd32768, -16'sd1);
      send_field(-16'sd1, -16'sd32768);
      send_field(16'sd21845, -16'sd21846);

      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         if (n % 100 == 0) begin
            mode = $urandom_range(0, 3);
            req_gaps_on   = (mode != 1) && (mode != 3);
            rsp_stalls_on = (mode != 2) && (mode != 3);
         end
         // hold responses back while requests stream in, so the pipe fills
         if (n == 300) begin
            hold_rsp    = 1'b1;
            req_gaps_on = 1'b0;
         end
         random_field(fx, fy);
         send_field(fx, fy);
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
rtl/chf_pkg.sv
rtl/chf_stage.sv
rtl/compass_heading_from_field_core.sv
sim/compass_heading_checker.sv
sim/testbench.sv
